/* rtl/ilvd_pkg.sv */
// shared types, codes and helpers of the integer list varint decoder
package ilvd_pkg;

  localparam int LenW      = 24;
  localparam int FieldW    = 29;
  localparam int TagW      = 32;
  localparam int ValW      = 64;
  localparam int GroupBits = 7;
  localparam int MaxGroups = 10;
  localparam int AdvSteps  = 4;

  localparam logic [LenW-1:0] CountMax = {LenW{1'b1}};

  localparam logic [FieldW-1:0] ListFieldReset  = FieldW'(3);
  localparam logic [FieldW-1:0] ValueFieldReset = FieldW'(1);

  // parse modes
  localparam logic [3:0] MODE_OUTER_TAG    = 4'd0;
  localparam logic [3:0] MODE_SEG_LEN      = 4'd1;
  localparam logic [3:0] MODE_OUTER_VARINT = 4'd2;
  localparam logic [3:0] MODE_SKIP         = 4'd3;
  localparam logic [3:0] MODE_INNER_TAG    = 4'd4;
  localparam logic [3:0] MODE_PACKED_LEN   = 4'd5;
  localparam logic [3:0] MODE_INNER_VALUE  = 4'd6;
  localparam logic [3:0] MODE_PACKED_VALUE = 4'd7;
  localparam logic [3:0] MODE_STOPPED      = 4'd8;
  localparam logic [3:0] MODE_IDLE         = 4'd9;

  // wire types
  localparam logic [2:0] WIRE_VARINT = 3'd0;
  localparam logic [2:0] WIRE_I64    = 3'd1;
  localparam logic [2:0] WIRE_LEN    = 3'd2;
  localparam logic [2:0] WIRE_I32    = 3'd5;

  // done status codes
  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NO_LIST   = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;

  // config register indexes
  localparam logic CFG_LIST_FIELD  = 1'b0;
  localparam logic CFG_VALUE_FIELD = 1'b1;

  typedef logic [3:0] mode_t;

  typedef struct packed {
    mode_t               mode;
    logic [LenW-1:0]     pos;
    logic [ValW-1:0]     acc;
    logic [3:0]          grp;
    logic [TagW-1:0]     tag;
    logic [LenW-1:0]     seg_end;
    logic [LenW-1:0]     pk_end;
    logic [LenW-1:0]     skip;
    logic [LenW-1:0]     cnt;
    logic [1:0]          status;
  } parse_state_t;

  function automatic parse_state_t clear_state();
    parse_state_t s;
    s.mode    = MODE_OUTER_TAG;
    s.pos     = '0;
    s.acc     = '0;
    s.grp     = '0;
    s.tag     = '0;
    s.seg_end = '0;
    s.pk_end  = '0;
    s.skip    = '0;
    s.cnt     = '0;
    s.status  = ST_NO_LIST;
    return s;
  endfunction

  // length v does not fit between position c and limit lim
  function automatic logic too_long(input logic [ValW-1:0] v, input logic [LenW:0] c,
                                    input logic [LenW:0] lim);
    logic [LenW:0] room;
    room = (c < lim) ? (lim - c) : '0;
    return (|v[ValW-1:LenW+1]) || (v[LenW:0] > room);
  endfunction

endpackage

/* rtl/int64_list_varint_decoder.sv */
// integer list varint decoder: byte stream in, list values and per-message done out
//
// Takes one message byte per cycle unless out_tready stalls the result register, and
// gives at most one result per byte. Each byte goes through an input register, then
// one pass of tag/length/varint logic that updates the per-message parse registers
// and loads the result register; the output register lets a new byte enter while a
// result waits.
// A result carries a value flag in tuser (the list entry in tdata) and, on the
// message's final byte, tlast with the entry count and status in tdata.
// Configuration writes are always taken (cfg_ready is tied high).
module int64_list_varint_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // cfg_index: 0 list field number, 1 value field number
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [28:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata: data_byte[7:0], message_length[31:8]
  input  logic [31:0] in_tdata,
  // in_tuser: first_byte
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata: value[63:0], entry_count[87:64], status[89:88], zero pad[95:90]
  output logic [95:0] out_tdata,
  // out_tuser: value_valid
  output logic        out_tuser,
  // out_tlast: done_res
  output logic        out_tlast
);

  localparam int LenW = ilvd_pkg::LenW;
  localparam int ValW = ilvd_pkg::ValW;

  logic [ilvd_pkg::FieldW-1:0] list_fn_r;
  logic [ilvd_pkg::FieldW-1:0] value_fn_r;

  logic            s1_valid_r;
  logic [7:0]      s1_data_r;
  logic            s1_first_r;
  logic [LenW-1:0] s1_len_r;

  ilvd_pkg::parse_state_t state_r;
  ilvd_pkg::parse_state_t state_nxt;

  logic            out_tvalid_r;
  logic            out_vv_r;
  logic [ValW-1:0] out_value_r;
  logic            out_done_r;
  logic [LenW-1:0] out_cnt_r;
  logic [1:0]      out_status_r;

  logic            fire;
  logic            active;
  logic            has_result;
  logic            got_nxt;
  logic [ValW-1:0] word_nxt;
  logic            final_nxt;

  assign cfg_ready  = 1'b1;
  assign fire       = s1_valid_r && (!out_tvalid_r || out_tready);
  assign in_tready  = !s1_valid_r || fire;
  assign active     = s1_first_r || (state_r.mode != ilvd_pkg::MODE_IDLE);
  assign has_result = active && (got_nxt || final_nxt);

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_vv_r;
  assign out_tlast  = out_done_r;
  assign out_tdata  = {6'd0, out_status_r, out_cnt_r, out_value_r};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_fn_r  <= ilvd_pkg::ListFieldReset;
      value_fn_r <= ilvd_pkg::ValueFieldReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ilvd_pkg::CFG_LIST_FIELD:  list_fn_r  <= cfg_data;
        ilvd_pkg::CFG_VALUE_FIELD: value_fn_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_data_r  <= in_tdata[7:0];
      s1_len_r   <= in_tdata[31:8];
      s1_first_r <= in_tuser;
    end
  end

  // one byte through the parser
  always_comb begin
    ilvd_pkg::parse_state_t s;
    logic [LenW:0]   c;
    logic [LenW:0]   cur_len;
    logic [LenW:0]   bound;
    logic [LenW:0]   sum;
    logic [ValW-1:0] v;
    logic [ValW-1:0] acc_new;
    logic [5:0]      shamt;
    logic [2:0]      wire_t;
    logic            have;
    logic            fin;
    s       = s1_first_r ? ilvd_pkg::clear_state() : state_r;
    cur_len = (s1_len_r == '0) ? (LenW+1)'(1) : {1'b0, s1_len_r};
    c       = {1'b0, s.pos} + (LenW+1)'(1);
    got_nxt  = 1'b0;
    word_nxt = '0;
    have    = 1'b0;
    fin     = 1'b1;
    v       = '0;
    sum     = '0;
    wire_t  = '0;
    shamt   = 6'({2'b00, s.grp} * 6'd7);
    acc_new = s.acc;
    bound   = cur_len;

    if (s.mode == ilvd_pkg::MODE_SKIP) begin
      if (s.skip != '0) s.skip = s.skip - 1'b1;
      fin = 1'b0;
    end else if (s.mode <= ilvd_pkg::MODE_PACKED_VALUE) begin
      if (s.mode <= ilvd_pkg::MODE_OUTER_VARINT) bound = cur_len;
      else if (s.mode == ilvd_pkg::MODE_PACKED_VALUE) bound = {1'b0, s.pk_end};
      else bound = {1'b0, s.seg_end};
      if (s.grp < 4'(ilvd_pkg::MaxGroups))
        acc_new = s.acc | ({57'd0, s1_data_r[6:0]} << shamt);
      s.acc = acc_new;
      if (s.grp < 4'(ilvd_pkg::MaxGroups)) s.grp = s.grp + 1'b1;
      if (!s1_data_r[7] || c >= bound) begin
        have = 1'b1;
        v    = acc_new;
        fin  = 1'b0;
      end
    end

    // completion and region-end settling, up to AdvSteps chained steps
    for (int i = 0; i < ilvd_pkg::AdvSteps; i++) begin
      if (!fin) begin
        if (have) begin
          have   = 1'b0;
          wire_t = v[2:0];
          unique case (s.mode)
            ilvd_pkg::MODE_OUTER_TAG: begin
              s.tag = v[34:3];
              unique case (wire_t)
                ilvd_pkg::WIRE_LEN:    s.mode = ilvd_pkg::MODE_SEG_LEN;
                ilvd_pkg::WIRE_VARINT: s.mode = ilvd_pkg::MODE_OUTER_VARINT;
                ilvd_pkg::WIRE_I32: begin
                  s.skip = LenW'(4);
                  s.mode = ilvd_pkg::MODE_SKIP;
                end
                ilvd_pkg::WIRE_I64: begin
                  s.skip = LenW'(8);
                  s.mode = ilvd_pkg::MODE_SKIP;
                end
                default: begin
                  s.status = ilvd_pkg::ST_MALFORMED;
                  s.mode   = ilvd_pkg::MODE_STOPPED;
                end
              endcase
            end
            ilvd_pkg::MODE_SEG_LEN: begin
              if (ilvd_pkg::too_long(v, c, cur_len)) begin
                s.status = ilvd_pkg::ST_MALFORMED;
                s.mode   = ilvd_pkg::MODE_STOPPED;
              end else if (s.tag == {3'b000, list_fn_r}) begin
                sum       = c + v[LenW:0];
                s.status  = ilvd_pkg::ST_FOUND;
                s.seg_end = sum[LenW-1:0];
                s.mode    = ilvd_pkg::MODE_INNER_TAG;
              end else begin
                s.skip = v[LenW-1:0];
                s.mode = ilvd_pkg::MODE_SKIP;
              end
            end
            ilvd_pkg::MODE_OUTER_VARINT: s.mode = ilvd_pkg::MODE_OUTER_TAG;
            ilvd_pkg::MODE_INNER_TAG: begin
              s.tag = v[34:3];
              if (s.tag == {3'b000, value_fn_r} && wire_t == ilvd_pkg::WIRE_LEN)
                s.mode = ilvd_pkg::MODE_PACKED_LEN;
              else if (s.tag == {3'b000, value_fn_r} && wire_t == ilvd_pkg::WIRE_VARINT)
                s.mode = ilvd_pkg::MODE_INNER_VALUE;
              else begin
                s.status = ilvd_pkg::ST_MALFORMED;
                s.mode   = ilvd_pkg::MODE_STOPPED;
              end
            end
            ilvd_pkg::MODE_PACKED_LEN: begin
              if (ilvd_pkg::too_long(v, c, {1'b0, s.seg_end})) begin
                s.status = ilvd_pkg::ST_MALFORMED;
                s.mode   = ilvd_pkg::MODE_STOPPED;
              end else begin
                sum      = c + v[LenW:0];
                s.pk_end = sum[LenW-1:0];
                s.mode   = ilvd_pkg::MODE_PACKED_VALUE;
              end
            end
            ilvd_pkg::MODE_INNER_VALUE: begin
              got_nxt  = 1'b1;
              word_nxt = v;
              if (s.cnt != ilvd_pkg::CountMax) s.cnt = s.cnt + 1'b1;
              s.mode = ilvd_pkg::MODE_INNER_TAG;
            end
            ilvd_pkg::MODE_PACKED_VALUE: begin
              got_nxt  = 1'b1;
              word_nxt = v;
              if (s.cnt != ilvd_pkg::CountMax) s.cnt = s.cnt + 1'b1;
            end
            default: ;
          endcase
        end
        s.acc = '0;
        s.grp = '0;
        fin   = 1'b1;
        unique case (s.mode) inside
          ilvd_pkg::MODE_OUTER_TAG: begin
            if (c >= cur_len) s.mode = ilvd_pkg::MODE_STOPPED;
          end
          ilvd_pkg::MODE_SEG_LEN, ilvd_pkg::MODE_OUTER_VARINT: begin
            // varint starting at the message end reads as zero
            if (c >= cur_len) begin
              have = 1'b1;
              v    = '0;
              fin  = 1'b0;
            end
          end
          ilvd_pkg::MODE_INNER_TAG: begin
            if (c >= {1'b0, s.seg_end}) s.mode = ilvd_pkg::MODE_STOPPED;
          end
          ilvd_pkg::MODE_PACKED_LEN, ilvd_pkg::MODE_INNER_VALUE: begin
            if (c >= {1'b0, s.seg_end}) begin
              have = 1'b1;
              v    = '0;
              fin  = 1'b0;
            end
          end
          ilvd_pkg::MODE_PACKED_VALUE: begin
            if (c >= {1'b0, s.pk_end}) begin
              s.mode = ilvd_pkg::MODE_INNER_TAG;
              fin    = 1'b0;
            end
          end
          ilvd_pkg::MODE_SKIP: begin
            if (s.skip == '0) begin
              s.mode = ilvd_pkg::MODE_OUTER_TAG;
              fin    = 1'b0;
            end
          end
          default: ;
        endcase
      end
    end

    s.pos     = c[LenW-1:0];
    final_nxt = (c >= cur_len);
    if (final_nxt) s.mode = ilvd_pkg::MODE_IDLE;
    state_nxt = s;
  end

  // per-message parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ilvd_pkg::clear_state();
    end else if (fire && active) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (fire) begin
      out_tvalid_r <= has_result;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && has_result) begin
      out_vv_r     <= got_nxt;
      out_value_r  <= word_nxt;
      out_done_r   <= final_nxt;
      out_cnt_r    <= final_nxt ? state_nxt.cnt : '0;
      out_status_r <= final_nxt ? state_nxt.status : 2'd0;
    end
  end

  // every result carries a value or closes a message
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_vv_r || out_done_r))
    else $error("result with neither value nor done");

  // no entries can be counted before the list field is found
  a_count_no_list: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_done_r && out_status_r == ilvd_pkg::ST_NO_LIST)
      |-> (out_cnt_r == '0))
    else $error("entries counted without a list field");

  // only a first byte restarts a finished message
  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !s1_first_r && state_r.mode == ilvd_pkg::MODE_IDLE)
      |=> (state_r.mode == ilvd_pkg::MODE_IDLE))
    else $error("finished message resumed without a first byte");

  // a byte after the final one gives no result
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !s1_first_r && state_r.mode == ilvd_pkg::MODE_IDLE) |=> !out_tvalid_r)
    else $error("result produced after the final byte");

endmodule

/* verif/int64_list_varint_decoder_tb.sv */
// testbench for the integer list varint decoder: directed byte table, then random messages
`timescale 1ns / 1ps

module int64_list_varint_decoder_tb;
  import ilvd_pkg::*;

  localparam int PhaseItems = 270;
  localparam logic [FieldW-1:0] FieldTop = '1;

  typedef struct packed {
    logic            vld;
    logic [63:0]     val;
    logic            fin;
    logic [LenW-1:0] cnt;
    logic [1:0]      st;
  } decoded_t;

  typedef enum logic [1:0] {PREDICT, FIXED_RES, FIXED_NONE} row_kind_t;

  typedef struct packed {
    logic [7:0]      b;
    logic            first;
    logic [LenW-1:0] len;
    row_kind_t       how;
    decoded_t        res;
  } row_t;

  localparam decoded_t DoneNoList = '{1'b0, 64'd0, 1'b1, 24'd0, ST_NO_LIST};
  localparam decoded_t DoneBad    = '{1'b0, 64'd0, 1'b1, 24'd0, ST_MALFORMED};

  localparam row_t Directed [24] = '{
    // no first byte after reset: a lone varint field fills the message
    '{8'h00, 1'b0, 24'd1, FIXED_RES, DoneNoList},
    // longest length, message left open
    '{8'h00, 1'b1, 24'hFFFFFF, PREDICT, '0},
    // zero length acts as one
    '{8'h00, 1'b1, 24'd0, FIXED_RES, DoneNoList},
    // unknown wire type
    '{8'h1B, 1'b1, 24'd1, FIXED_RES, DoneBad},
    // fixed32 skip running past the message end
    '{8'h0D, 1'b1, 24'd2, PREDICT, '0},
    '{8'hAA, 1'b0, 24'd2, FIXED_RES, DoneNoList},
    // list segment longer than the message
    '{8'h1A, 1'b1, 24'd3, PREDICT, '0},
    '{8'h05, 1'b0, 24'd3, PREDICT, '0},
    '{8'h00, 1'b0, 24'd3, FIXED_RES, DoneBad},
    // single value cut short by the segment end
    '{8'h1A, 1'b1, 24'd4, PREDICT, '0},
    '{8'h02, 1'b0, 24'd4, PREDICT, '0},
    '{8'h08, 1'b0, 24'd4, PREDICT, '0},
    '{8'hFF, 1'b0, 24'd4, FIXED_RES, '{1'b1, 64'd127, 1'b1, 24'd1, ST_FOUND}},
    // packed run holding one value
    '{8'h1A, 1'b1, 24'd5, PREDICT, '0},
    '{8'h03, 1'b0, 24'd5, PREDICT, '0},
    '{8'h0A, 1'b0, 24'd5, PREDICT, '0},
    '{8'h01, 1'b0, 24'd5, PREDICT, '0},
    '{8'h7F, 1'b0, 24'd5, PREDICT, '0},
    // foreign inner field
    '{8'h1A, 1'b1, 24'd3, PREDICT, '0},
    '{8'h01, 1'b0, 24'd3, PREDICT, '0},
    '{8'h10, 1'b0, 24'd3, FIXED_RES, DoneBad},
    // length drops mid message, then a byte after the final one
    '{8'h00, 1'b1, 24'd5, PREDICT, '0},
    '{8'h00, 1'b0, 24'd2, FIXED_RES, DoneNoList},
    '{8'hAA, 1'b0, 24'd2, FIXED_NONE, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [28:0] cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  int64_list_varint_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // decoder mirror: configuration and per-message parse state
  logic [FieldW-1:0] list_fn;
  logic [FieldW-1:0] value_fn;
  mode_t             m_mode;
  logic [LenW-1:0]   m_pos;
  logic [63:0]       m_acc;
  int                m_shift;
  logic [31:0]       m_tag;
  logic [LenW-1:0]   m_seg_end;
  logic [LenW-1:0]   m_pk_end;
  logic [LenW-1:0]   m_skip;
  logic [LenW-1:0]   m_count;
  logic [1:0]        m_status;
  logic [63:0]       m_len;
  bit                got_v;
  logic [63:0]       got_w;

  decoded_t   decoded_due[$];
  logic [7:0] msg_bytes[$];
  int         fail_cnt = 0;
  int         live_items = 0;
  bit         in_calm = 1'b0;

  function automatic void clear_msg();
    m_mode    = MODE_OUTER_TAG;
    m_pos     = '0;
    m_acc     = '0;
    m_shift   = 0;
    m_tag     = '0;
    m_seg_end = '0;
    m_pk_end  = '0;
    m_skip    = '0;
    m_count   = '0;
    m_status  = ST_NO_LIST;
  endfunction

  function automatic logic [63:0] span(input logic [63:0] c, input logic [63:0] lim);
    return (c < lim) ? lim - c : 64'd0;
  endfunction

  function automatic void halt_parse();
    m_status = ST_MALFORMED;
    m_mode   = MODE_STOPPED;
  endfunction

  function automatic void record_value(input logic [63:0] v);
    got_v = 1'b1;
    got_w = v;
    if (m_count != CountMax) m_count = m_count + 1'b1;
  endfunction

  // finish a varint if one is complete, then close every read that starts at its region end
  function automatic void settle(input logic [63:0] c, input bit have_in,
                                 input logic [63:0] v_in);
    bit          have;
    bit          more;
    logic [63:0] v;
    logic [2:0]  wt;
    have = have_in;
    v    = v_in;
    more = 1'b1;
    while (more) begin
      if (have) begin
        have = 1'b0;
        wt   = v[2:0];
        case (m_mode)
          MODE_OUTER_TAG: begin
            m_tag = v[34:3];
            if (wt == WIRE_LEN) m_mode = MODE_SEG_LEN;
            else if (wt == WIRE_VARINT) m_mode = MODE_OUTER_VARINT;
            else if (wt == WIRE_I32) begin
              m_skip = 24'd4;
              m_mode = MODE_SKIP;
            end else if (wt == WIRE_I64) begin
              m_skip = 24'd8;
              m_mode = MODE_SKIP;
            end else halt_parse();
          end
          MODE_SEG_LEN: begin
            if (v > span(c, m_len)) halt_parse();
            else if (m_tag == {3'b000, list_fn}) begin
              m_status  = ST_FOUND;
              m_seg_end = 24'(c + v);
              m_mode    = MODE_INNER_TAG;
            end else begin
              m_skip = 24'(v);
              m_mode = MODE_SKIP;
            end
          end
          MODE_OUTER_VARINT: m_mode = MODE_OUTER_TAG;
          MODE_INNER_TAG: begin
            m_tag = v[34:3];
            if (m_tag == {3'b000, value_fn} && wt == WIRE_LEN) m_mode = MODE_PACKED_LEN;
            else if (m_tag == {3'b000, value_fn} && wt == WIRE_VARINT)
              m_mode = MODE_INNER_VALUE;
            else halt_parse();
          end
          MODE_PACKED_LEN: begin
            if (v > span(c, {40'b0, m_seg_end})) halt_parse();
            else begin
              m_pk_end = 24'(c + v);
              m_mode   = MODE_PACKED_VALUE;
            end
          end
          MODE_INNER_VALUE: begin
            record_value(v);
            m_mode = MODE_INNER_TAG;
          end
          MODE_PACKED_VALUE: record_value(v);
          default: ;
        endcase
      end
      m_acc   = '0;
      m_shift = 0;
      more    = 1'b0;
      case (m_mode)
        MODE_OUTER_TAG: if (c >= m_len) m_mode = MODE_STOPPED;
        MODE_SEG_LEN, MODE_OUTER_VARINT: begin
          if (c >= m_len) begin
            have = 1'b1;
            v    = '0;
            more = 1'b1;
          end
        end
        MODE_INNER_TAG: if (c >= {40'b0, m_seg_end}) m_mode = MODE_STOPPED;
        MODE_PACKED_LEN, MODE_INNER_VALUE: begin
          if (c >= {40'b0, m_seg_end}) begin
            have = 1'b1;
            v    = '0;
            more = 1'b1;
          end
        end
        MODE_PACKED_VALUE: begin
          if (c >= {40'b0, m_pk_end}) begin
            m_mode = MODE_INNER_TAG;
            more   = 1'b1;
          end
        end
        MODE_SKIP: begin
          if (m_skip == '0) begin
            m_mode = MODE_OUTER_TAG;
            more   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  endfunction

  // advance the mirror by one accepted byte; returns 1 when the byte yields a result
  function automatic bit decode_byte(input logic [7:0] b, input bit first,
                                     input logic [LenW-1:0] len, output decoded_t r);
    logic [63:0] c;
    logic [63:0] bound;
    bit          fin;
    r = '0;
    if (first) clear_msg();
    else if (m_mode == MODE_IDLE) return 1'b0;
    m_len = (len == '0) ? 64'd1 : {40'b0, len};
    got_v = 1'b0;
    got_w = '0;
    c = {40'b0, m_pos} + 64'd1;
    if (m_mode == MODE_SKIP) begin
      if (m_skip != '0) m_skip = m_skip - 1'b1;
      settle(c, 1'b0, 64'd0);
    end else if (m_mode <= MODE_PACKED_VALUE) begin
      bound = (m_mode <= MODE_OUTER_VARINT) ? m_len :
              (m_mode == MODE_PACKED_VALUE) ? {40'b0, m_pk_end} : {40'b0, m_seg_end};
      if (m_shift < 64) m_acc = m_acc | ({57'b0, b[6:0]} << m_shift);
      if (m_shift < 70) m_shift = m_shift + GroupBits;
      if (!b[7] || c >= bound) settle(c, 1'b1, m_acc);
    end
    m_pos = c[LenW-1:0];
    fin = (c >= m_len);
    if (fin) m_mode = MODE_IDLE;
    if (!got_v && !fin) return 1'b0;
    r.vld = got_v;
    r.val = got_w;
    r.fin = fin;
    r.cnt = fin ? m_count : '0;
    r.st  = fin ? m_status : '0;
    return 1'b1;
  endfunction

  // message builders
  function automatic void put_varint(ref logic [7:0] q[$], input logic [63:0] v);
    logic [63:0] w;
    w = v;
    while (w > 64'd127) begin
      q.insert(q.size(), {1'b1, w[6:0]});
      w = w >> GroupBits;
    end
    q.insert(q.size(), {1'b0, w[6:0]});
  endfunction

  function automatic void put_tag(ref logic [7:0] q[$], input logic [FieldW-1:0] fn,
                                  input logic [2:0] wt);
    put_varint(q, {32'b0, fn, wt});
  endfunction

  // a value varint: extremes, assorted sizes, or raw groups up to past the tenth
  function automatic void put_number(ref logic [7:0] q[$]);
    int n;
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) q.insert(q.size(), {i < n - 1, 7'($urandom)});
    end else begin
      case ($urandom_range(0, 7))
        0: put_varint(q, 64'd0);
        1: put_varint(q, '1);
        2: put_varint(q, 64'h8000_0000_0000_0000);
        3: put_varint(q, 64'h7FFF_FFFF_FFFF_FFFF);
        4: put_varint(q, 64'($urandom_range(0, 300)));
        5: put_varint(q, {$urandom, $urandom});
        default: put_varint(q, {$urandom, $urandom} >> $urandom_range(0, 63));
      endcase
    end
  endfunction

  function automatic void put_skip_field(ref logic [7:0] q[$]);
    logic [FieldW-1:0] fn;
    int                n;
    fn = FieldW'($urandom_range(1, 40));
    if (fn == list_fn) fn = fn + 1'b1;
    case ($urandom_range(0, 3))
      0: begin
        put_tag(q, fn, WIRE_VARINT);
        put_number(q);
      end
      1: begin
        put_tag(q, fn, WIRE_I64);
        repeat (8) q.insert(q.size(), 8'($urandom));
      end
      2: begin
        put_tag(q, fn, WIRE_I32);
        repeat (4) q.insert(q.size(), 8'($urandom));
      end
      default: begin
        n = $urandom_range(0, 6);
        put_tag(q, fn, WIRE_LEN);
        put_varint(q, 64'(n));
        repeat (n) q.insert(q.size(), 8'($urandom));
      end
    endcase
  endfunction

  function automatic void put_list_body(ref logic [7:0] q[$], input bit flawed);
    logic [7:0] blob[$];
    logic [2:0] wt;
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 1) == 1) begin
        blob.delete();
        repeat ($urandom_range(0, 4)) put_number(blob);
        put_tag(q, value_fn, WIRE_LEN);
        put_varint(q, 64'(blob.size()));
        foreach (blob[i]) q.insert(q.size(), blob[i]);
      end else begin
        put_tag(q, value_fn, WIRE_VARINT);
        put_number(q);
      end
    end
    if (flawed) begin
      case ($urandom_range(0, 3))
        0: begin
          wt = ($urandom_range(0, 1) == 1) ? WIRE_LEN : WIRE_VARINT;
          put_tag(q, value_fn ^ FieldW'(1), wt);
          put_number(q);
        end
        // value tag with nothing left in the segment
        1: put_tag(q, value_fn, WIRE_VARINT);
        2: put_tag(q, value_fn, ($urandom_range(0, 1) == 1) ? WIRE_I32 : WIRE_I64);
        default: begin
          put_tag(q, value_fn, WIRE_LEN);
          put_varint(q, 64'($urandom_range(5, 300)));
          put_number(q);
        end
      endcase
    end
  endfunction

  function automatic void build_message(ref logic [7:0] q[$]);
    logic [7:0] body[$];
    logic [2:0] wt;
    int         kind;
    q.delete();
    kind = $urandom_range(0, 15);
    if (kind < 2) begin
      repeat ($urandom_range(1, 10)) q.insert(q.size(), 8'($urandom));
      return;
    end
    repeat ($urandom_range(0, 2)) put_skip_field(q);
    if (kind == 2) begin
      do wt = 3'($urandom);
      while (wt == WIRE_VARINT || wt == WIRE_I64 || wt == WIRE_LEN || wt == WIRE_I32);
      put_tag(q, FieldW'($urandom), wt);
      put_number(q);
      return;
    end
    if (kind == 3) begin
      put_skip_field(q);
      return;
    end
    put_list_body(body, kind == 4 || kind == 5);
    put_tag(q, list_fn, WIRE_LEN);
    if (kind == 6) put_varint(q, 64'(body.size() + $urandom_range(1, 50)));
    else put_varint(q, 64'(body.size()));
    foreach (body[i]) q.insert(q.size(), body[i]);
    repeat ($urandom_range(0, 1)) put_skip_field(q);
    if (kind == 7 && q.size() > 1) begin
      repeat ($urandom_range(1, q.size() - 1)) void'(q.pop_back());
    end
    if (kind == 8) q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
  endfunction

  // drive one input item and log what it should produce
  task automatic send_item(input logic [7:0] b, input bit first, input logic [LenW-1:0] len,
                           input row_kind_t how, input decoded_t given);
    int       gap;
    bit       hit;
    decoded_t r;
    gap = in_calm ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {len, b};
    in_tuser  <= first;
    do @(posedge clk); while (!in_tready);
    if (first || m_mode != MODE_IDLE) live_items++;
    hit = decode_byte(b, first, len, r);
    if (how == FIXED_RES) decoded_due.insert(decoded_due.size(), given);
    else if (how == PREDICT && hit) decoded_due.insert(decoded_due.size(), r);
  endtask

  task automatic send_message();
    int              n;
    int              style;
    logic [LenW-1:0] len;
    logic [LenW-1:0] lb;
    build_message(msg_bytes);
    n = msg_bytes.size();
    len = LenW'(n);
    style = $urandom_range(0, 29);
    in_calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      lb = len;
      if (style == 0) lb = LenW'($urandom);
      else if (style == 1 && i < n - 1) lb = len + LenW'($urandom_range(1, 100));
      else if (style == 2) lb = '0;
      else if (style == 3) lb = CountMax;
      send_item(msg_bytes[i], i == 0, lb, PREDICT, '0);
    end
    // trailing bytes after the final one are dropped by the block
    if (style == 4) repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0, len, PREDICT, '0);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (decoded_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [FieldW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_LIST_FIELD) list_fn = val;
    else value_fn = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input logic [FieldW-1:0] lf, input logic [FieldW-1:0] vf,
                              input bit retune);
    int start;
    bit paused;
    if (retune) begin
      drain();
      write_reg(CFG_LIST_FIELD, lf);
      write_reg(CFG_VALUE_FIELD, vf);
    end
    start = live_items;
    paused = 1'b0;
    while (live_items - start < PhaseItems) begin
      // hold the stream once until every pending result is out
      if (!paused && live_items - start > PhaseItems / 2) begin
        paused = 1'b1;
        drain();
      end
      send_message();
    end
  endtask

  // result side: random stalls with calm stretches
  initial begin
    int hold;
    bit calm;
    out_tready = 1'b0;
    calm = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      hold = calm ? 0 : $urandom_range(0, 12);
      @(negedge clk);
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin
    decoded_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_due.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result: vld=%0b val=%h done=%0b cnt=%0d st=%0d",
                   out_tuser, out_tdata[63:0], out_tlast, out_tdata[87:64], out_tdata[89:88]);
      end else begin
        want = decoded_due.pop_front();
        if (out_tuser !== want.vld || out_tdata[63:0] !== want.val || out_tlast !== want.fin ||
            out_tdata[87:64] !== want.cnt || out_tdata[89:88] !== want.st) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: exp v=%0b %h d=%0b c=%0d s=%0d / got v=%0b %h d=%0b c=%0d s=%0d",
                     want.vld, want.val, want.fin, want.cnt, want.st, out_tuser,
                     out_tdata[63:0], out_tlast, out_tdata[87:64], out_tdata[89:88]);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_LIST_FIELD;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    list_fn   = ListFieldReset;
    value_fn  = ValueFieldReset;
    clear_msg();
    m_len = 64'd1;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (Directed[i])
      send_item(Directed[i].b, Directed[i].first, Directed[i].len, Directed[i].how,
                Directed[i].res);

    random_phase(ListFieldReset, ValueFieldReset, 1'b0);
    random_phase(FieldW'(1), FieldW'(1), 1'b1);
    random_phase(FieldTop, FieldTop, 1'b1);
    random_phase(FieldW'(1), FieldTop, 1'b1);
    random_phase(FieldW'($urandom_range(2, 1000)), FieldW'($urandom_range(2, 1000)), 1'b1);
    random_phase(FieldTop, FieldW'(1), 1'b1);

    drain();
    repeat (10) @(posedge clk);
    if (decoded_due.size() != 0) begin
      $display("%0d expected results never arrived", decoded_due.size());
      fail_cnt += decoded_due.size();
    end
    if (fail_cnt == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
rtl/ilvd_pkg.sv
rtl/int64_list_varint_decoder.sv
verif/int64_list_varint_decoder_tb.sv
